>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/jvwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jvwt_pkg;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [50:0] TQ_MAX = 51'sd2147483647;
  localparam logic signed [50:0] TQ_MIN = -51'sd2147483648;

  localparam logic [2:0] CFG_UPPER_LIMIT = 3'd0;
  localparam logic [2:0] CFG_LOWER_LIMIT = 3'd1;
  localparam logic [2:0] CFG_SPRING_ZONE_WIDTH = 3'd2;
  localparam logic [2:0] CFG_DAMP_ZONE_WIDTH = 3'd3;
  localparam logic [2:0] CFG_SPRING_STIFFNESS = 3'd4;
  localparam logic [2:0] CFG_SPRING_DAMPING = 3'd5;
  localparam logic [2:0] CFG_OUTER_DAMPING = 3'd6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REARM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOTION,
    ST_DIV,
    ST_MUL_PD,
    ST_MUL_TOT,
    ST_ZONE,
    ST_D_HI,
    ST_D_LO,
    ST_K_HI,
    ST_K_LO,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               op;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] torque;
    logic               beyond_wall;
  } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/joint_virtual_wall_torque.sv
`timescale 1ns / 1ps
`default_nettype none

// Joint virtual wall: per sample, a damping or spring-plus-damping limit torque from joint
// position and velocity (Q16.16). A rearm item goes from idle straight to the output state. A
// control sample first lying beyond the limits goes from the motion check straight to output;
// otherwise a 16-step restoring divider may run to recompute the wall scale. One shared 32x18
// multiplier does two scale products and two partial products per gain term, one product a
// cycle. A result waiting on the output holds the next one back. Registers must be written
// only while idle, by the user; the block itself does not enforce this.

`include "assert_macros.svh"

module joint_virtual_wall_torque import jvwt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  state_e state_q, state_d;
  logic signed [31:0] upper_q, lower_q;
  logic [30:0] spring_w_q, damp_w_q, k_q, kd_q, outer_q;
  logic armed_q, armed_d, moving_q, moving_d, init_q, init_d;
  logic [16:0] scale_q, scale_d;
  logic signed [31:0] q_q, q_d, dq_q, dq_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0] cnt_q, cnt_d;
  logic [31:0] s_pd_q, s_pd_d;
  logic [32:0] s_tot_q, s_tot_d;
  logic spring_q, spring_d, xneg_q, xneg_d, beyond_q, beyond_d;
  logic [33:0] xmag_q, xmag_d;
  logic [48:0] tmag_q, tmag_d;
  logic signed [50:0] tacc_q, tacc_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic [31:0] total;
  logic signed [33:0] q34, lo_edge, hi_edge;
  logic below_lo, above_hi, leaving, outside;
  logic signed [32:0] lim_dist, dist_neg;
  logic [32:0] dmag, rem_sh, rem_sub;
  logic rem_ge;
  logic [15:0] quo_nxt;
  logic [16:0] s_new;
  logic [31:0] mul_a, dqmag;
  logic [17:0] mul_b;
  logic [49:0] prod;
  logic [30:0] dgain;
  logic signed [34:0] q35, d_max, pd_max, d_min, pd_min, x_val, x_neg;
  logic is_damp;
  logic [48:0] term;
  logic signed [50:0] term_s;
  logic term_neg;
  logic [31:0] sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0;
      lower_q <= '0;
      spring_w_q <= '0;
      damp_w_q <= '0;
      k_q <= '0;
      kd_q <= '0;
      outer_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UPPER_LIMIT: upper_q <= cfg_data_i;
        CFG_LOWER_LIMIT: lower_q <= cfg_data_i;
        CFG_SPRING_ZONE_WIDTH: spring_w_q <= cfg_data_i[30:0];
        CFG_DAMP_ZONE_WIDTH: damp_w_q <= cfg_data_i[30:0];
        CFG_SPRING_STIFFNESS: k_q <= cfg_data_i[30:0];
        CFG_SPRING_DAMPING: kd_q <= cfg_data_i[30:0];
        CFG_OUTER_DAMPING: outer_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign total = {1'b0, spring_w_q} + {1'b0, damp_w_q};
  assign q34 = {{2{q_q[31]}}, q_q};
  assign lo_edge = {{2{lower_q[31]}}, lower_q} + {2'b00, total};
  assign hi_edge = {{2{upper_q[31]}}, upper_q} - {2'b00, total};
  assign below_lo = q34 < lo_edge;
  assign above_hi = q34 > hi_edge;
  assign leaving = below_lo ? (!dq_q[31] && (dq_q != '0)) : dq_q[31];
  assign outside = (q_q < lower_q) || (q_q > upper_q);
  assign lim_dist = below_lo ? ({q_q[31], q_q} - {lower_q[31], lower_q})
                             : ({q_q[31], q_q} - {upper_q[31], upper_q});
  assign dist_neg = -lim_dist;
  assign dmag = lim_dist[32] ? dist_neg : lim_dist;

  // restoring divide step, remainder always below total
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, total};
  assign rem_sub = rem_sh - {1'b0, total};
  assign quo_nxt = {quo_q[14:0], rem_ge};
  assign s_new = {1'b0, quo_nxt};

  assign dqmag = dq_q[31] ? 32'(-dq_q) : dq_q;
  assign dgain = spring_q ? kd_q : outer_q;

  assign q35 = {{3{q_q[31]}}, q_q};
  assign d_max = {{3{upper_q[31]}}, upper_q} - {2'b00, s_tot_q};
  assign pd_max = {{3{upper_q[31]}}, upper_q} - {3'b000, s_pd_q};
  assign d_min = {{3{lower_q[31]}}, lower_q} + {2'b00, s_tot_q};
  assign pd_min = {{3{lower_q[31]}}, lower_q} + {3'b000, s_pd_q};
  assign is_damp = ((d_max <= q35) && (q35 <= pd_max)) || ((pd_min <= q35) && (q35 <= d_min));
  assign x_val = (q35 > pd_max) ? (pd_max - q35) : (pd_min - q35);
  assign x_neg = -x_val;

  assign prod = {18'b0, mul_a} * {32'b0, mul_b};
  assign term = tmag_q + {18'b0, prod[46:16]};
  assign term_s = {2'b00, term};

  assign sat = (tacc_q > TQ_MAX) ? TQ_MAX[31:0] :
               (tacc_q < TQ_MIN) ? TQ_MIN[31:0] : tacc_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      armed_q <= 1'b0;
      moving_q <= 1'b0;
      scale_q <= ONE_Q16;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      moving_q <= moving_d;
      scale_q <= scale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q <= init_d;
    q_q <= q_d;
    dq_q <= dq_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    s_pd_q <= s_pd_d;
    s_tot_q <= s_tot_d;
    spring_q <= spring_d;
    xneg_q <= xneg_d;
    xmag_q <= xmag_d;
    tmag_q <= tmag_d;
    tacc_q <= tacc_d;
    beyond_q <= beyond_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d = state_q;
    armed_d = armed_q;
    moving_d = moving_q;
    scale_d = scale_q;
    init_d = init_q;
    q_d = q_q;
    dq_d = dq_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    s_pd_d = s_pd_q;
    s_tot_d = s_tot_q;
    spring_d = spring_q;
    xneg_d = xneg_q;
    xmag_d = xmag_q;
    tmag_d = tmag_q;
    tacc_d = tacc_q;
    beyond_d = beyond_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a = '0;
    mul_b = '0;
    term_neg = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          q_d = in_data_i.position;
          dq_d = in_data_i.velocity;
          beyond_d = 1'b0;
          tacc_d = '0;
          if (in_data_i.op == OP_REARM) begin
            armed_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_MOTION;
          end
        end
      end
      ST_MOTION: begin
        state_d = ST_MUL_PD;
        if (!armed_q && outside) begin
          beyond_d = 1'b1;
          state_d = ST_DONE;
        end else if ((!armed_q || moving_q) && !(below_lo || above_hi)) begin
          armed_d = 1'b1;
          moving_d = 1'b0;
          scale_d = ONE_Q16;
        end else if (!armed_q || (moving_q && leaving)) begin
          // first sample inside a zone sets the scale, later ones only grow it
          init_d = !armed_q;
          armed_d = 1'b1;
          moving_d = 1'b1;
          if (dmag >= {1'b0, total}) begin
            scale_d = ONE_Q16;
          end else begin
            rem_d = dmag[31:0];
            quo_d = '0;
            cnt_d = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        quo_d = quo_nxt;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          if (init_q || (s_new > scale_q)) begin
            scale_d = s_new;
          end
          state_d = ST_MUL_PD;
        end
      end
      ST_MUL_PD: begin
        mul_a = {1'b0, spring_w_q};
        mul_b = {1'b0, scale_q};
        s_pd_d = prod[47:16];
        state_d = ST_MUL_TOT;
      end
      ST_MUL_TOT: begin
        mul_a = total;
        mul_b = {1'b0, scale_q};
        s_tot_d = prod[48:16];
        state_d = ST_ZONE;
      end
      ST_ZONE: begin
        tacc_d = '0;
        spring_d = !is_damp;
        xneg_d = x_val[34];
        xmag_d = x_val[34] ? x_neg[33:0] : x_val[33:0];
        if (is_damp || (q35 > pd_max) || (q35 < pd_min)) begin
          state_d = ST_D_HI;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_D_HI: begin
        mul_a = {1'b0, dgain};
        mul_b = {2'b00, dqmag[31:16]};
        tmag_d = prod[48:0];
        state_d = ST_D_LO;
      end
      ST_D_LO: begin
        mul_a = {1'b0, dgain};
        mul_b = {2'b00, dqmag[15:0]};
        // damping opposes velocity
        term_neg = !dq_q[31];
        tacc_d = term_neg ? (tacc_q - term_s) : (tacc_q + term_s);
        state_d = spring_q ? ST_K_HI : ST_DONE;
      end
      ST_K_HI: begin
        mul_a = {1'b0, k_q};
        mul_b = xmag_q[33:16];
        tmag_d = prod[48:0];
        state_d = ST_K_LO;
      end
      ST_K_LO: begin
        mul_a = {1'b0, k_q};
        mul_b = {2'b00, xmag_q[15:0]};
        term_neg = xneg_q;
        tacc_d = term_neg ? (tacc_q - term_s) : (tacc_q + term_s);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.torque = sat;
          out_d.beyond_wall = beyond_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `ASSERT_ALWAYS(a_scale_max, scale_q <= ONE_Q16, "width scale above 1.0")
  `ASSERT_ALWAYS(a_scale_rest, moving_q || (scale_q == ONE_Q16), "scale not 1.0 while at rest")
  `ASSERT_ALWAYS(a_beyond_zero, !(out_valid_q && out_q.beyond_wall) || (out_q.torque == '0), "beyond result with torque")
  `ASSERT_NEXT(a_rearm, in_valid_i && in_ready_o && (in_data_i.op == OP_REARM), !armed_q, "rearm kept armed")

endmodule

`default_nettype wire
